// File: hdl/rfalu_pkg.sv
// Package for the register file ALU: sizes, action codes, sequencer states
// and the control/status structs shared by the top level and the divider.
// No dependencies.
`timescale 1ns / 1ps

package rfalu_pkg;

	// register file geometry (index width is fixed by the request fields)
	localparam int IDX_W    = 5;
	localparam int NUM_REGS = 2 ** IDX_W;
	localparam int DW       = 32;
	localparam int IMM_W    = 31;
	localparam int CNT_W    = $clog2(DW);

	// access mark bits
	localparam int MARK_W = 2;
	localparam int MARK_RD = 0;
	localparam int MARK_WR = 1;

	typedef enum logic [3:0] {
		ACT_MOV   = 4'd0,
		ACT_ADD   = 4'd1,
		ACT_SUB   = 4'd2,
		ACT_MUL   = 4'd3,
		ACT_DIV   = 4'd4,
		ACT_REM   = 4'd5,
		ACT_AND   = 4'd6,
		ACT_OR    = 4'd7,
		ACT_XOR   = 4'd8,
		ACT_NOT   = 4'd9,
		ACT_EQ    = 4'd10,
		ACT_NE    = 4'd11,
		ACT_LT    = 4'd12,
		ACT_GE    = 4'd13,
		ACT_CLEAR = 4'd14,
		ACT_QUERY = 4'd15
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	// divider control and status
	typedef struct packed {
		logic start;
		logic want_rem;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic dz;
	} div_sts_t;

endpackage

// File: hdl/rfalu_req_if.sv
// Request channel of the register file ALU: valid/ready plus the action fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfalu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [4:0]  dest_index;
	logic [4:0]  src1_index;
	logic [4:0]  src2_index;
	logic        use_imm;
	logic [30:0] immediate;

	modport source (
		output valid, action, dest_index, src1_index, src2_index, use_imm, immediate,
		input  ready
	);
	modport sink (
		input  valid, action, dest_index, src1_index, src2_index, use_imm, immediate,
		output ready
	);
endinterface

// File: hdl/rfalu_rsp_if.sv
// Result channel of the register file ALU: valid/ready plus the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface rfalu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               wrote;
	logic               branch_taken;
	logic               div_by_zero;
	logic [1:0]         access_mark;

	modport source (
		output valid, result_value, wrote, branch_taken, div_by_zero, access_mark,
		input  ready
	);
	modport sink (
		input  valid, result_value, wrote, branch_taken, div_by_zero, access_mark,
		output ready
	);
endinterface

// File: hdl/rfalu_regmem.sv
// Register value store: one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero after reset.
// Depends on rfalu_pkg.
`timescale 1ns / 1ps

module rfalu_regmem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rfalu_pkg::IDX_W-1:0] raddr1,
	input  logic [rfalu_pkg::IDX_W-1:0] raddr2,
	output logic [rfalu_pkg::DW-1:0]    rdata1,
	output logic [rfalu_pkg::DW-1:0]    rdata2,
	input  logic                      we,
	input  logic [rfalu_pkg::IDX_W-1:0] waddr,
	input  logic [rfalu_pkg::DW-1:0]    wdata
);
	import rfalu_pkg::*;

	logic [DW-1:0]       mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [DW-1:0]       rd1_q;
	logic [DW-1:0]       rd2_q;
	logic                rv1_q;
	logic                rv2_q;

	// storage array and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd1_q <= mem[raddr1];
		rd2_q <= mem[raddr2];
	end

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv1_q <= 1'b0;
			rv2_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rv1_q <= vld_q[raddr1];
			rv2_q <= vld_q[raddr2];
		end
	end

	assign rdata1 = rv1_q ? rd1_q : '0;
	assign rdata2 = rv2_q ? rd2_q : '0;

endmodule

// File: hdl/rfalu_div.sv
// Signed divider, one quotient bit per cycle (restoring, on magnitudes).
// Zero divisor finishes at once with quotient all ones / remainder = dividend.
// Depends on rfalu_pkg.
`timescale 1ns / 1ps

module rfalu_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rfalu_pkg::div_ctl_t    ctl,
	input  logic [rfalu_pkg::DW-1:0] dividend,
	input  logic [rfalu_pkg::DW-1:0] divisor,
	output rfalu_pkg::div_sts_t    sts,
	output logic [rfalu_pkg::DW-1:0] result
);
	import rfalu_pkg::*;

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic             dz_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW:0]      rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    mb_q;
	logic             negq_q;
	logic             negr_q;
	logic             wrem_q;
	logic [DW-1:0]    res_q;

	logic          na;
	logic          nb;
	logic [DW-1:0] ma;
	logic [DW-1:0] mb;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;

	// operand magnitudes and one restoring step
	always_comb begin
		na     = dividend[DW-1];
		nb     = divisor[DW-1];
		ma     = na ? (~dividend + 1'b1) : dividend;
		mb     = nb ? (~divisor + 1'b1) : divisor;
		rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
		diff   = rem_sh - {1'b0, mb_q};
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			dz_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				dz_q  <= (divisor == '0);
				cnt_q <= '0;
				if (divisor == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			wrem_q <= ctl.want_rem;
			negq_q <= na ^ nb;
			negr_q <= na;
			mb_q   <= mb;
			quo_q  <= ma;
			rem_q  <= '0;
			if (divisor == '0) begin
				res_q <= ctl.want_rem ? dividend : '1;
			end
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end else if (fin_q) begin
			// sign fix-up: quotient toward zero, remainder follows dividend
			if (wrem_q) begin
				res_q <= negr_q ? (~rem_q[DW-1:0] + 1'b1) : rem_q[DW-1:0];
			end else begin
				res_q <= negq_q ? (~quo_q + 1'b1) : quo_q;
			end
		end
	end

	assign sts.done = done_q;
	assign sts.dz   = dz_q;
	assign result   = res_q;

endmodule

// File: hdl/register_file_alu_with_access_marks.sv
// Top level: request sequencer, ALU, access marks and result register.
// Depends on rfalu_pkg, rfalu_req_if, rfalu_rsp_if, rfalu_regmem, rfalu_div.
`timescale 1ns / 1ps

// Thirty-two 32-bit registers, held in a two-read one-write synchronous
// memory, feed a signed ALU; each request reads its operands, computes,
// writes the destination back for the value actions (mov through not), and
// returns one result. One request is in flight at a time: most actions pass
// through accept, memory read, execute and commit, mul included since its
// product is registered in the execute cycle. div and rem also wait on the
// divider, which produces one quotient bit per cycle; a zero divisor ends
// its wait at once. The next request is taken as soon as the previous one
// has committed, even while its result still waits in the output register;
// a commit waits only if that register is still full. Registers read as
// zero and all access marks are clear after reset, with no clearing pass.
module register_file_alu_with_access_marks (
	input  logic          clk,
	input  logic          arst_n,
	rfalu_req_if.sink     req,
	rfalu_rsp_if.source   rsp
);
	import rfalu_pkg::*;

	state_t state_q;
	state_t state_d;

	// request fields
	action_t          act_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] rs1_q;
	logic [IDX_W-1:0] rs2_q;
	logic             imm_sel_q;
	logic [IMM_W-1:0] imm_q;

	// execute results
	logic [DW-1:0] res_q;
	logic [DW-1:0] prod_q;
	logic          br_q;
	logic [MARK_W-1:0] mark_q;

	logic [MARK_W-1:0] marks_q [NUM_REGS];

	// output register
	logic              ovalid_q;
	logic [DW-1:0]     oval_q;
	logic              owrote_q;
	logic              obr_q;
	logic              odz_q;
	logic [MARK_W-1:0] omark_q;

	logic [DW-1:0] rd1;
	logic [DW-1:0] rd2;
	logic [DW-1:0] imm_ext;
	logic [DW-1:0] op_mv;
	logic [DW-1:0] op_b;
	logic [DW-1:0] ex_val;
	logic          ex_br;
	logic [DW-1:0] fin_val;
	logic          fin_wrote;
	logic          fin_dz;
	logic          mark_rs1;
	logic          mark_rs2;
	logic          accept;
	logic          commit;
	logic          mem_we;

	div_ctl_t      div_ctl;
	div_sts_t      div_sts;
	logic [DW-1:0] div_res;

	rfalu_regmem u_regmem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr1 (rs1_q),
		.raddr2 (rs2_q),
		.rdata1 (rd1),
		.rdata2 (rd2),
		.we     (mem_we),
		.waddr  (rd_q),
		.wdata  (fin_val)
	);

	rfalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (rd1),
		.divisor  (op_b),
		.sts      (div_sts),
		.result   (div_res)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.want_rem = (act_q == ACT_REM);
		commit           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (act_q == ACT_DIV || act_q == ACT_REM) begin
					div_ctl.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!ovalid_q || rsp.ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action_t'(req.action);
			rd_q      <= req.dest_index;
			rs1_q     <= req.src1_index;
			rs2_q     <= req.src2_index;
			imm_sel_q <= req.use_imm;
			imm_q     <= req.immediate;
		end
	end

	// operand selection and combinational ALU
	always_comb begin
		imm_ext  = DW'(imm_q);
		op_mv    = imm_sel_q ? imm_ext : rd1;
		op_b     = (imm_sel_q && act_q inside {[ACT_ADD:ACT_XOR]}) ? imm_ext : rd2;
		ex_val   = '0;
		ex_br    = 1'b0;
		mark_rs1 = 1'b0;
		mark_rs2 = 1'b0;
		case (act_q)
			ACT_MOV:   ex_val = op_mv;
			ACT_NOT:   ex_val = ~op_mv;
			ACT_ADD:   ex_val = rd1 + op_b;
			ACT_SUB:   ex_val = rd1 - op_b;
			ACT_AND:   ex_val = rd1 & op_b;
			ACT_OR:    ex_val = rd1 | op_b;
			ACT_XOR:   ex_val = rd1 ^ op_b;
			ACT_EQ:    ex_br  = (rd1 == rd2);
			ACT_NE:    ex_br  = (rd1 != rd2);
			ACT_LT:    ex_br  = ($signed(rd1) < $signed(rd2));
			ACT_GE:    ex_br  = !($signed(rd1) < $signed(rd2));
			ACT_QUERY: ex_val = rd1;
			default:   ex_val = '0;
		endcase
		// read marks: immediate operands and query leave none
		if (act_q inside {ACT_MOV, ACT_NOT}) begin
			mark_rs1 = !imm_sel_q;
		end else if (act_q inside {[ACT_ADD:ACT_XOR]}) begin
			mark_rs1 = 1'b1;
			mark_rs2 = !imm_sel_q;
		end else if (act_q inside {[ACT_EQ:ACT_GE]}) begin
			mark_rs1 = 1'b1;
			mark_rs2 = 1'b1;
		end
	end

	// execute-stage registers; the product is registered before use
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			res_q  <= ex_val;
			prod_q <= rd1 * op_b;
			br_q   <= ex_br;
			mark_q <= (act_q == ACT_QUERY) ? marks_q[rs1_q] : '0;
		end
	end

	// commit: result select and write back
	always_comb begin
		case (act_q)
			ACT_MUL:          fin_val = prod_q;
			ACT_DIV, ACT_REM: fin_val = div_res;
			default:          fin_val = res_q;
		endcase
		fin_wrote = act_q inside {[ACT_MOV:ACT_NOT]};
		fin_dz    = (act_q == ACT_DIV || act_q == ACT_REM) && div_sts.dz;
		mem_we    = commit && fin_wrote;
	end

	// sticky access marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				marks_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_EXEC) begin
				if (act_q == ACT_CLEAR) begin
					for (int i = 0; i < NUM_REGS; i++) begin
						marks_q[i] <= '0;
					end
				end else begin
					if (mark_rs1) begin
						marks_q[rs1_q][MARK_RD] <= 1'b1;
					end
					if (mark_rs2) begin
						marks_q[rs2_q][MARK_RD] <= 1'b1;
					end
				end
			end
			if (mem_we) begin
				marks_q[rd_q][MARK_WR] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (commit) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			oval_q   <= fin_val;
			owrote_q <= fin_wrote;
			obr_q    <= br_q;
			odz_q    <= fin_dz;
			omark_q  <= mark_q;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.result_value = $signed(oval_q);
	assign rsp.wrote        = owrote_q;
	assign rsp.branch_taken = obr_q;
	assign rsp.div_by_zero  = odz_q;
	assign rsp.access_mark  = omark_q;

endmodule
